### rtl/mqsb_pkg.sv
package mqsb_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int STORE_DEPTH = 256;

  localparam int QID_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int SLOT_W   = $clog2(STORE_DEPTH + 1);

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t NULL_LINK = SLOT_W'(STORE_DEPTH);
  localparam slot_t LAST_SLOT = SLOT_W'(STORE_DEPTH - 1);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic slot_ok(slot_t s);
    return s < NULL_LINK;
  endfunction

endpackage

### rtl/mqsb_req_if.sv
interface mqsb_req_if;
  import mqsb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [QID_W-1:0]         queue_id;
  logic signed [DATA_W-1:0] write_data;

  modport source (output valid, output op, output queue_id, output write_data, input ready);
  modport sink   (input valid, input op, input queue_id, input write_data, output ready);
endinterface

### rtl/mqsb_rsp_if.sv
interface mqsb_rsp_if;
  import mqsb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_data;
  logic [STATUS_W-1:0]      status;
  logic                     store_full;
  logic                     queue_empty;

  modport source (output valid, output read_data, output status, output store_full,
                  output queue_empty, input ready);
  modport sink   (input valid, input read_data, input status, input store_full,
                  input queue_empty, output ready);
endinterface

### rtl/multi_queue_shared_buffer_core.sv
// channel  dir  payload                                         transfer when
// req      in   op, queue_id, write_data                        valid && ready
// rsp      out  read_data, status, store_full, queue_empty      valid && ready
//
// Each item is handled in steps: first the link and value store reads, then
// the list updates and the load of the result register.
// An item may be taken while the previous result still waits; a stalled
// result holds the update step until the result register frees.
// Reset is synchronous and immediate: a fill mark stands in for the initial
// free-list links, so no clearing pass runs.
module multi_queue_shared_buffer_core (
  input logic        clk,
  input logic        rst,
  mqsb_req_if.sink   req,
  mqsb_rsp_if.source rsp
);
  import mqsb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mqsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mqsb_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_op          (req.op),
    .req_queue_id    (req.queue_id),
    .req_write_data  (req.write_data),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_data   (rsp.read_data),
    .rsp_status      (rsp.status),
    .rsp_store_full  (rsp.store_full),
    .rsp_queue_empty (rsp.queue_empty)
  );

endmodule

### rtl/mqsb_ctrl.sv
module mqsb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  mqsb_pkg::dp_stat_t stat,
  output mqsb_pkg::dp_cmd_t  cmd
);
  import mqsb_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (!stat.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    req_ready  = (state == S_IDLE);
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.commit = (state == S_EXEC) && !stat.out_busy;
  end

endmodule

### rtl/mqsb_datapath.sv
module mqsb_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  mqsb_pkg::dp_cmd_t                  cmd,
  output mqsb_pkg::dp_stat_t                 stat,
  input  logic                               req_op,
  input  logic [mqsb_pkg::QID_W-1:0]         req_queue_id,
  input  logic signed [mqsb_pkg::DATA_W-1:0] req_write_data,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic signed [mqsb_pkg::DATA_W-1:0] rsp_read_data,
  output logic [mqsb_pkg::STATUS_W-1:0]      rsp_status,
  output logic                               rsp_store_full,
  output logic                               rsp_queue_empty
);
  import mqsb_pkg::*;

  slot_t              link_mem [STORE_DEPTH];
  logic [DATA_W-1:0]  val_mem  [STORE_DEPTH];

  slot_t              heads [NUM_QUEUES];
  slot_t              tails [NUM_QUEUES];
  slot_t              free_head;
  slot_t              fill_count;

  op_t                op_r;
  logic [QID_W-1:0]   q_r;
  logic [DATA_W-1:0]  wd_r;
  slot_t              slot_r;
  logic               fresh_r;
  slot_t              link_rd;
  logic [DATA_W-1:0]  val_rd;

  logic               req_q_ok;
  slot_t              rd_slot;

  logic               q_ok;
  slot_t              head_q;
  slot_t              tail_q;
  slot_t              link_eff;
  logic               enq_ok;
  logic               deq_ok;
  slot_t              free_head_next;
  slot_t              head_next;
  logic               head_we;
  logic               tail_we;
  slot_t              tail_wd;
  logic               link_we;
  logic [ADDR_W-1:0]  link_wa;
  slot_t              link_wd;
  logic [DATA_W-1:0]  rd_value;
  status_t            status_c;

  // pick the slot whose link is read: free-list head or queue head
  always_comb begin
    req_q_ok = int'(req_queue_id) < NUM_QUEUES;
    if (op_t'(req_op) == OP_ENQ) begin
      rd_slot = free_head;
    end else if (req_q_ok) begin
      rd_slot = heads[req_queue_id];
    end else begin
      rd_slot = NULL_LINK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(req_op);
      q_r     <= req_queue_id;
      wd_r    <= req_write_data;
      slot_r  <= rd_slot;
      fresh_r <= rd_slot >= fill_count;
      link_rd <= link_mem[rd_slot[ADDR_W-1:0]];
      val_rd  <= val_mem[rd_slot[ADDR_W-1:0]];
    end
  end

  always_comb begin
    q_ok   = int'(q_r) < NUM_QUEUES;
    head_q = heads[q_r];
    tail_q = tails[q_r];

    // slots at or above the fill mark use their reset link, the next slot, in place of the stored link
    if (fresh_r) begin
      link_eff = (slot_r == LAST_SLOT) ? NULL_LINK : slot_r + SLOT_W'(1);
    end else begin
      link_eff = link_rd;
    end

    enq_ok = q_ok && (op_r == OP_ENQ) && slot_ok(slot_r);
    deq_ok = q_ok && (op_r == OP_DEQ) && slot_ok(slot_r);

    free_head_next = free_head;
    head_next      = head_q;
    head_we        = 1'b0;
    tail_we        = 1'b0;
    tail_wd        = tail_q;
    link_we        = 1'b0;
    link_wa        = tail_q[ADDR_W-1:0];
    link_wd        = slot_r;
    rd_value       = '0;
    status_c       = ST_OK;

    if (!q_ok) begin
      status_c = (op_r == OP_ENQ) ? ST_OVERFLOW : ST_UNDERFLOW;
    end else if (op_r == OP_ENQ) begin
      if (!enq_ok) begin
        status_c = ST_OVERFLOW;
      end else begin
        free_head_next = link_eff;
        tail_we        = 1'b1;
        tail_wd        = slot_r;
        if (!slot_ok(head_q) || !slot_ok(tail_q)) begin
          head_we   = 1'b1;
          head_next = slot_r;
        end else begin
          link_we = 1'b1;
          link_wa = tail_q[ADDR_W-1:0];
          link_wd = slot_r;
        end
      end
    end else begin
      if (!deq_ok) begin
        status_c = ST_UNDERFLOW;
      end else begin
        rd_value       = val_rd;
        head_we        = 1'b1;
        free_head_next = slot_r;
        link_we        = 1'b1;
        link_wa        = slot_r[ADDR_W-1:0];
        link_wd        = free_head;
        if (slot_r == tail_q) begin
          head_next = NULL_LINK;
          tail_we   = 1'b1;
          tail_wd   = NULL_LINK;
        end else begin
          head_next = link_eff;
        end
      end
    end

    stat.out_busy = rsp_valid && !rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && link_we) link_mem[link_wa] <= link_wd;
    if (cmd.commit && enq_ok) val_mem[slot_r[ADDR_W-1:0]] <= wd_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        heads[i] <= NULL_LINK;
        tails[i] <= NULL_LINK;
      end
      free_head  <= '0;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (head_we) heads[q_r] <= head_next;
        if (tail_we) tails[q_r] <= tail_wd;
        free_head <= free_head_next;
        if (enq_ok && (slot_r == fill_count)) fill_count <= fill_count + SLOT_W'(1);
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_read_data   <= rd_value;
      rsp_status      <= status_c;
      rsp_store_full  <= !slot_ok(free_head_next);
      rsp_queue_empty <= !q_ok || !slot_ok(head_next);
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mqsb_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 34;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    status_t                  status;
    logic                     store_full;
    logic                     queue_empty;
  } queue_result_t;

  typedef struct {
    op_t               op;
    logic [QID_W-1:0]  qid;
    logic [DATA_W-1:0] data;
    bit                typed;
    queue_result_t     want;
  } directed_row_t;

  logic clk;
  logic rst;

  mqsb_req_if req_ch ();
  mqsb_rsp_if rsp_ch ();

  multi_queue_shared_buffer_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slot_t             next_slot  [STORE_DEPTH];
  logic [DATA_W-1:0] slot_value [STORE_DEPTH];
  slot_t             head_slot  [NUM_QUEUES];
  slot_t             tail_slot  [NUM_QUEUES];
  slot_t             free_slot;

  queue_result_t pending_results [$];
  directed_row_t directed_rows [$];
  int            mismatches;
  bit            no_idle;
  int            hold_asked;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_queue_lists();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      next_slot[i]  = slot_t'(i + 1);
      slot_value[i] = '0;
    end
    for (int i = 0; i < NUM_QUEUES; i++) begin
      head_slot[i] = NULL_LINK;
      tail_slot[i] = NULL_LINK;
    end
    free_slot = '0;
  endfunction

  function automatic queue_result_t apply_queue_op(op_t o, logic [QID_W-1:0] q,
                                                   logic [DATA_W-1:0] d);
    queue_result_t r;
    slot_t         s;
    slot_t         t;
    r.read_data   = '0;
    r.status      = ST_OK;
    r.queue_empty = 1'b1;
    if (int'(q) >= NUM_QUEUES) begin
      r.status = (o == OP_ENQ) ? ST_OVERFLOW : ST_UNDERFLOW;
    end else if (o == OP_ENQ) begin
      s = free_slot;
      if (s >= NULL_LINK) begin
        r.status = ST_OVERFLOW;
      end else begin
        t = tail_slot[q];
        free_slot = next_slot[s[ADDR_W-1:0]];
        if (head_slot[q] >= NULL_LINK || t >= NULL_LINK) begin
          head_slot[q] = s;
        end else begin
          next_slot[t[ADDR_W-1:0]] = s;
        end
        next_slot[s[ADDR_W-1:0]]  = NULL_LINK;
        tail_slot[q]              = s;
        slot_value[s[ADDR_W-1:0]] = d;
      end
    end else begin
      s = head_slot[q];
      if (s >= NULL_LINK) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.read_data  = slot_value[s[ADDR_W-1:0]];
        head_slot[q] = next_slot[s[ADDR_W-1:0]];
        if (head_slot[q] >= NULL_LINK) begin
          head_slot[q] = NULL_LINK;
          tail_slot[q] = NULL_LINK;
        end
        next_slot[s[ADDR_W-1:0]] = free_slot;
        free_slot                = s;
      end
    end
    if (int'(q) < NUM_QUEUES) r.queue_empty = (head_slot[q] >= NULL_LINK);
    r.store_full = (free_slot >= NULL_LINK);
    return r;
  endfunction

  function automatic queue_result_t result_of(logic [DATA_W-1:0] d, status_t st,
                                              logic full, logic empty);
    queue_result_t r;
    r.read_data   = d;
    r.status      = st;
    r.store_full  = full;
    r.queue_empty = empty;
    return r;
  endfunction

  function automatic void plan_row(op_t o, logic [QID_W-1:0] q, logic [DATA_W-1:0] d,
                                   bit typed, queue_result_t want);
    directed_row_t row;
    row.op    = o;
    row.qid   = q;
    row.data  = d;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(7))
      0:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_item(op_t o, logic [QID_W-1:0] q, logic [DATA_W-1:0] d,
                            bit typed, queue_result_t want);
    bit            taken;
    queue_result_t predicted;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= o;
    req_ch.queue_id   <= q;
    req_ch.write_data <= d;
    do begin
      @(negedge clk);
      taken = req_ch.ready;
      if (taken) begin
        predicted = apply_queue_op(o, q, d);
        pending_results.push_back(typed ? want : predicted);
      end
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int count, int enq_pct, int qid_max);
    op_t o;
    for (int i = 0; i < count; i++) begin
      o = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
      offer_item(o, QID_W'($urandom_range(qid_max)), pick_data(), 1'b0,
                 result_of('0, ST_OK, 1'b0, 1'b0));
    end
  endtask

  initial begin : rsp_pace
    int hold_seen;
    hold_seen = 0;
    forever begin
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          rsp_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk);
    end
  end

  always @(negedge clk) begin : result_check
    queue_result_t got;
    queue_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.read_data   = rsp_ch.read_data;
      got.status      = status_t'(rsp_ch.status);
      got.store_full  = rsp_ch.store_full;
      got.queue_empty = rsp_ch.queue_empty;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data || got.status !== want.status ||
            got.store_full !== want.store_full || got.queue_empty !== want.queue_empty) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected data %h status %s full %b empty %b",
                     want.read_data, want.status.name(), want.store_full, want.queue_empty);
            $display("           actual data %h status %0d full %b empty %b",
                     got.read_data, rsp_ch.status, got.store_full, got.queue_empty);
          end
        end
      end
    end
  end

  initial begin
    mismatches        = 0;
    no_idle           = 1'b0;
    hold_asked        = 0;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OP_ENQ;
    req_ch.queue_id   <= '0;
    req_ch.write_data <= '0;
    clear_queue_lists();

    plan_row(OP_DEQ, 3'd0, 32'h0, 1'b1, result_of(32'h0, ST_UNDERFLOW, 1'b0, 1'b1));
    plan_row(OP_DEQ, 3'd7, 32'h0, 1'b1, result_of(32'h0, ST_UNDERFLOW, 1'b0, 1'b1));
    plan_row(OP_ENQ, 3'd0, 32'h7FFF_FFFF, 1'b1, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_ENQ, 3'd0, 32'h8000_0000, 1'b1, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_ENQ, 3'd7, 32'hFFFF_FFFF, 1'b1, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_ENQ, 3'd7, 32'h0, 1'b1, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_ENQ, 3'd5, 32'h5555_5555, 1'b1, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_ENQ, 3'd2, 32'hAAAA_AAAA, 1'b1, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_DEQ, 3'd0, 32'h0, 1'b1, result_of(32'h7FFF_FFFF, ST_OK, 1'b0, 1'b0));
    plan_row(OP_DEQ, 3'd0, 32'hFFFF_FFFF, 1'b1,
             result_of(32'h8000_0000, ST_OK, 1'b0, 1'b1));
    plan_row(OP_DEQ, 3'd0, 32'h0, 1'b1, result_of(32'h0, ST_UNDERFLOW, 1'b0, 1'b1));
    plan_row(OP_ENQ, 3'd0, 32'h1, 1'b0, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_DEQ, 3'd7, 32'h0, 1'b1, result_of(32'hFFFF_FFFF, ST_OK, 1'b0, 1'b0));
    plan_row(OP_ENQ, 3'd3, 32'h1234_5678, 1'b0, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_DEQ, 3'd7, 32'h0, 1'b1, result_of(32'h0, ST_OK, 1'b0, 1'b1));
    plan_row(OP_DEQ, 3'd5, 32'h0, 1'b1, result_of(32'h5555_5555, ST_OK, 1'b0, 1'b1));
    plan_row(OP_DEQ, 3'd2, 32'h0, 1'b1, result_of(32'hAAAA_AAAA, ST_OK, 1'b0, 1'b1));
    plan_row(OP_DEQ, 3'd0, 32'h0, 1'b1, result_of(32'h1, ST_OK, 1'b0, 1'b1));
    plan_row(OP_DEQ, 3'd3, 32'h0, 1'b0, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_DEQ, 3'd3, 32'h0, 1'b1, result_of(32'h0, ST_UNDERFLOW, 1'b0, 1'b1));
    plan_row(OP_ENQ, 3'd1, 32'h0000_FFFF, 1'b0, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_ENQ, 3'd4, 32'hFFFF_0000, 1'b0, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_ENQ, 3'd6, 32'h8000_0001, 1'b0, result_of(32'h0, ST_OK, 1'b0, 1'b0));
    plan_row(OP_DEQ, 3'd6, 32'h0, 1'b0, result_of(32'h0, ST_OK, 1'b0, 1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].op, directed_rows[i].qid, directed_rows[i].data,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    run_phase(300, 50, NUM_QUEUES - 1);
    drain_results();
    run_phase(400, 90, NUM_QUEUES - 1);
    no_idle = 1'b1;
    run_phase(400, 10, NUM_QUEUES - 1);
    no_idle = 1'b0;
    drain_results();
    hold_asked++;
    run_phase(350, 55, 1);
    run_phase(350, 50, NUM_QUEUES - 1);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mqsb_pkg.sv
rtl/mqsb_req_if.sv
rtl/mqsb_rsp_if.sv
rtl/mqsb_ctrl.sv
rtl/mqsb_datapath.sv
rtl/multi_queue_shared_buffer_core.sv
test/testbench.sv
